FILE: hw/rtl/tacut_pkg.sv
`timescale 1ns / 1ps
package tacut_pkg;

  localparam int MAX_EXTENT = 4096;
  localparam int POS_W      = 12;
  localparam int EXT_W      = 13;
  localparam int CNT_W      = 13;
  localparam int AREA_W     = 25;
  localparam int MEM_AW     = POS_W + 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic AXIS_HEIGHT = 1'b0;
  localparam logic AXIS_WIDTH  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_HEIGHT = 1'b1;

  typedef struct packed {
    logic [MEM_AW-1:0] addr;
    logic              we;
    logic              wd;
  } mark_req_t;

  typedef struct packed {
    logic [MEM_AW-1:0] addr;
    logic              we;
    logic [CNT_W-1:0]  wd;
  } cnt_req_t;

  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] r;
    r = v;
    if (v < EXT_W'(2)) r = EXT_W'(2);
    else if (v > EXT_W'(MAX_EXTENT)) r = EXT_W'(MAX_EXTENT);
    return r;
  endfunction

endpackage

FILE: hw/rtl/tacut_store.sv
`timescale 1ns / 1ps
module tacut_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              restart,
  input  tacut_pkg::mark_req_t    mark_req,
  input  tacut_pkg::cnt_req_t     cnt_req,
  output logic                    mark_rd,
  output logic [tacut_pkg::CNT_W-1:0] cnt_rd,
  output logic                    busy
);
  import tacut_pkg::*;

  logic             mark_mem [2**MEM_AW];
  logic [CNT_W-1:0] cnt_mem  [2**MEM_AW];

  logic [1:0]       pend_r, pend_nxt;
  logic             act_r, act_nxt;
  logic             sax_r, sax_nxt;
  logic [POS_W-1:0] scnt_r, scnt_nxt;

  logic [MEM_AW-1:0] mk_addr, cn_addr;
  logic              mk_we, cn_we, mk_wd;
  logic [CNT_W-1:0]  cn_wd;

  assign busy = act_r | (|pend_r);

  always_comb begin
    pend_nxt = pend_r;
    act_nxt  = act_r;
    sax_nxt  = sax_r;
    scnt_nxt = scnt_r;
    if (act_r) begin
      scnt_nxt = scnt_r + 1'b1;
      if (&scnt_r) begin
        act_nxt        = 1'b0;
        pend_nxt[sax_r] = 1'b0;
      end
    end else if (|pend_r) begin
      act_nxt  = 1'b1;
      sax_nxt  = pend_r[0] ? 1'b0 : 1'b1;
      scnt_nxt = '0;
    end
    pend_nxt = pend_nxt | restart;
  end

  always_comb begin
    if (act_r) begin
      mk_addr = {sax_r, scnt_r};
      cn_addr = {sax_r, scnt_r};
      mk_we   = 1'b1;
      cn_we   = 1'b1;
      mk_wd   = 1'b0;
      cn_wd   = '0;
    end else begin
      mk_addr = mark_req.addr;
      cn_addr = cnt_req.addr;
      mk_we   = mark_req.we;
      cn_we   = cnt_req.we;
      mk_wd   = mark_req.wd;
      cn_wd   = cnt_req.wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'b11;
      act_r  <= 1'b0;
      sax_r  <= 1'b0;
      scnt_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      act_r  <= act_nxt;
      sax_r  <= sax_nxt;
      scnt_r <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mk_we) mark_mem[mk_addr] <= mk_wd;
    mark_rd <= mark_mem[mk_addr];
  end

  always_ff @(posedge clk) begin
    if (cn_we) cnt_mem[cn_addr] <= cn_wd;
    cnt_rd <= cnt_mem[cn_addr];
  end

endmodule

FILE: hw/rtl/two_axis_cut_max_fragment_area_unit.sv
`timescale 1ns / 1ps
// Sheet cutter that reports the largest fragment area after every cut.
// Input stream: in_tuser selects the axis (0 height, 1 width), in_tdata holds
// the cut position. Each request gives one result on the output stream:
// out_tdata is largest height gap times largest width gap, out_tuser flags a
// cut that was repeated or out of range and changed nothing.
// Configuration channel: index 0 writes the sheet width, index 1 the sheet
// height (clamped to 2..4096); a write restarts that axis with no cuts.
// A cut at 0 or at or beyond the edge goes straight to the result; otherwise
// the mark memory is read and a repeated cut ends there. An applied cut walks
// to the nearest cuts on both sides, marks its position, lowers the count of
// the gap it splits (skipped for the first cut on the axis), raises the counts
// of the two new gaps, and steps the largest gap down until its count is
// nonzero, using single-port mark and count memories. One request at a time.
// After reset both axes are cleared in turn, and after a configuration write
// that axis; no request is taken then. A result waits in the output register
// while the receiver stalls; the next request is accepted meanwhile and holds
// at its end until the slot frees.
module two_axis_cut_max_fragment_area_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tacut_pkg::IN_DATA_W-1:0]   in_tdata,   // position[11:0], zero
  input  logic                              in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tacut_pkg::OUT_DATA_W-1:0]  out_tdata,  // max_area[24:0], zero
  output logic                              out_tuser,  // ignored
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tacut_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tacut_pkg::EXT_W-1:0]       cfg_data
);
  import tacut_pkg::*;

  typedef enum logic [3:0] {
    IDLE, MARK, LO, HI, DEC_RD, DEC_WR, INA_RD, INA_WR,
    INB_RD, INB_WR, LG_RD, LG_CHK, FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic             ax_r, ax_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, lo_r, lo_nxt;
  logic [EXT_W-1:0] hi_r, hi_nxt, lg_r, lg_nxt;
  logic             ign_r, ign_nxt;
  logic [EXT_W-1:0] ext_r [2];
  logic [EXT_W-1:0] ext_nxt [2];
  logic [EXT_W-1:0] lgst_r [2];
  logic [EXT_W-1:0] lgst_nxt [2];
  logic [1:0]       full_r, full_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [AREA_W-1:0] out_area_r, out_area_nxt;
  logic             out_ign_r, out_ign_nxt;

  mark_req_t        mk_req;
  cnt_req_t         cn_req;
  logic             mark_rd, busy;
  logic [CNT_W-1:0] cnt_rd;
  logic [1:0]       restart;

  logic [EXT_W-1:0]   whole, len_a, len_b, len_m1, ext_clamped;
  logic [2*EXT_W-1:0] prod;
  logic [POS_W-1:0]   in_pos;

  tacut_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .mark_req (mk_req),
    .cnt_req  (cn_req),
    .mark_rd  (mark_rd),
    .cnt_rd   (cnt_rd),
    .busy     (busy)
  );

  assign in_pos     = in_tdata[POS_W-1:0];
  assign in_tready  = (state_r == IDLE) && !busy;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-AREA_W){1'b0}}, out_area_r};
  assign out_tuser  = out_ign_r;

  assign whole       = hi_r - {1'b0, lo_r};
  assign len_a       = hi_r - {1'b0, pos_r};
  assign len_b       = {1'b0, pos_r} - {1'b0, lo_r};
  assign ext_clamped = clamp_extent(cfg_data);
  assign prod        = {{EXT_W{1'b0}}, lgst_r[AXIS_HEIGHT]} *
                       {{EXT_W{1'b0}}, lgst_r[AXIS_WIDTH]};

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lg_nxt        = lg_r;
    ign_nxt       = ign_r;
    ext_nxt       = ext_r;
    lgst_nxt      = lgst_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_area_nxt  = out_area_r;
    out_ign_nxt   = out_ign_r;
    restart       = 2'b00;
    len_m1        = '0;
    mk_req        = '{addr: {ax_r, pos_r}, we: 1'b0, wd: 1'b1};
    cn_req        = '{addr: {ax_r, {POS_W{1'b0}}}, we: 1'b0, wd: '0};

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHEET_WIDTH: begin
          ext_nxt[AXIS_WIDTH]  = ext_clamped;
          lgst_nxt[AXIS_WIDTH] = ext_clamped;
          full_nxt[AXIS_WIDTH] = 1'b1;
          restart[AXIS_WIDTH]  = 1'b1;
        end
        CFG_SHEET_HEIGHT: begin
          ext_nxt[AXIS_HEIGHT]  = ext_clamped;
          lgst_nxt[AXIS_HEIGHT] = ext_clamped;
          full_nxt[AXIS_HEIGHT] = 1'b1;
          restart[AXIS_HEIGHT]  = 1'b1;
        end
      endcase
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      IDLE: begin
        if (in_tvalid && in_tready) begin
          ax_nxt      = in_tuser;
          pos_nxt     = in_pos;
          mk_req.addr = {in_tuser, in_pos};
          if (in_pos == '0 || {1'b0, in_pos} >= ext_r[in_tuser]) begin
            ign_nxt   = 1'b1;
            state_nxt = FIN;
          end else begin
            ign_nxt   = 1'b0;
            state_nxt = MARK;
          end
        end
      end
      MARK: begin
        if (mark_rd) begin
          ign_nxt   = 1'b1;
          state_nxt = FIN;
        end else begin
          lo_nxt      = pos_r - 1'b1;
          mk_req.addr = {ax_r, lo_nxt};
          state_nxt   = LO;
        end
      end
      LO: begin
        if (lo_r == '0 || mark_rd) begin
          hi_nxt      = {1'b0, pos_r} + 1'b1;
          mk_req.addr = {ax_r, hi_nxt[POS_W-1:0]};
          state_nxt   = HI;
        end else begin
          lo_nxt      = lo_r - 1'b1;
          mk_req.addr = {ax_r, lo_nxt};
        end
      end
      HI: begin
        if (hi_r == ext_r[ax_r] || mark_rd) begin
          mk_req    = '{addr: {ax_r, pos_r}, we: 1'b1, wd: 1'b1};
          state_nxt = DEC_RD;
        end else begin
          hi_nxt      = hi_r + 1'b1;
          mk_req.addr = {ax_r, hi_nxt[POS_W-1:0]};
        end
      end
      DEC_RD: begin
        if (full_r[ax_r]) begin
          full_nxt[ax_r] = 1'b0;
          state_nxt      = INA_RD;
        end else begin
          len_m1      = whole - 1'b1;
          cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
          state_nxt   = DEC_WR;
        end
      end
      DEC_WR: begin
        len_m1      = whole - 1'b1;
        cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        cn_req.we   = 1'b1;
        cn_req.wd   = (cnt_rd == '0) ? '0 : cnt_rd - 1'b1;
        state_nxt   = INA_RD;
      end
      INA_RD: begin
        len_m1      = len_a - 1'b1;
        cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        state_nxt   = INA_WR;
      end
      INA_WR: begin
        len_m1      = len_a - 1'b1;
        cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        cn_req.we   = 1'b1;
        cn_req.wd   = cnt_rd + 1'b1;
        state_nxt   = INB_RD;
      end
      INB_RD: begin
        len_m1      = len_b - 1'b1;
        cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        state_nxt   = INB_WR;
      end
      INB_WR: begin
        len_m1      = len_b - 1'b1;
        cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        cn_req.we   = 1'b1;
        cn_req.wd   = cnt_rd + 1'b1;
        state_nxt   = LG_RD;
      end
      LG_RD: begin
        lg_nxt      = lgst_r[ax_r];
        len_m1      = lgst_r[ax_r] - 1'b1;
        cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        state_nxt   = LG_CHK;
      end
      LG_CHK: begin
        if (lg_r == EXT_W'(1) || cnt_rd != '0) begin
          lgst_nxt[ax_r] = lg_r;
          state_nxt      = FIN;
        end else begin
          lg_nxt      = lg_r - 1'b1;
          len_m1      = lg_r - EXT_W'(2);
          cn_req.addr = {ax_r, len_m1[POS_W-1:0]};
        end
      end
      FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_area_nxt  = prod[AREA_W-1:0];
          out_ign_nxt   = ign_r;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      ext_r       <= '{EXT_W'(MAX_EXTENT), EXT_W'(MAX_EXTENT)};
      lgst_r      <= '{EXT_W'(MAX_EXTENT), EXT_W'(MAX_EXTENT)};
      full_r      <= 2'b11;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ext_r       <= ext_nxt;
      lgst_r      <= lgst_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ax_r       <= ax_nxt;
    pos_r      <= pos_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lg_r       <= lg_nxt;
    ign_r      <= ign_nxt;
    out_area_r <= out_area_nxt;
    out_ign_r  <= out_ign_nxt;
  end

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready)
    else $error("request accepted during clearing pass");

  a_largest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    lgst_r[0] <= ext_r[0] && lgst_r[1] <= ext_r[1] &&
    lgst_r[0] != '0 && lgst_r[1] != '0)
    else $error("largest gap outside sheet extent");

  a_ignored_no_mark_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == MARK && mark_rd |-> !mk_req.we)
    else $error("repeated cut written");
`endif

endmodule
